@@ hw/rtl/ted_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ted_pkg
// Types, codes and helpers shared by the text encoding detector.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam logic [2:0] ENC_ANSI        = 3'd0;
  localparam logic [2:0] ENC_UTF8_MARK   = 3'd1;
  localparam logic [2:0] ENC_UTF16_LE    = 3'd2;
  localparam logic [2:0] ENC_UTF16_BE    = 3'd3;
  localparam logic [2:0] ENC_UTF8_NOMARK = 3'd4;

  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MATCH = 8'h80;

  localparam logic [1:0] HEAD_FULL = 2'd3;
  localparam logic [3:0] MAX_LEAD  = 4'd6;

  typedef struct packed {
    logic [1:0] bytes_seen;
    logic [7:0] head0;
    logic [7:0] head1;
    logic [7:0] head2;
    logic [2:0] cont_due;
    logic       all_ascii;
    logic       scan_invalid;
    logic       scan_stopped;
  } scan_state_t;

  typedef struct packed {
    logic [2:0] encoding;
    logic [1:0] mark_length;
  } result_t;

  localparam scan_state_t STATE_RESET = '{
    bytes_seen:   2'd0,
    head0:        8'd0,
    head1:        8'd0,
    head2:        8'd0,
    cont_due:     3'd0,
    all_ascii:    1'b1,
    scan_invalid: 1'b0,
    scan_stopped: 1'b0
  };

  function automatic logic [3:0] leading_ones(input logic [7:0] b);
    logic [3:0] n;
    casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ted_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ted_step
// Next scan state for one byte and the encoding class seen from that state.
// ----------------------------------------------------------------------------
module ted_step (
  input  wire ted_pkg::scan_state_t state,
  input  wire logic [7:0]           byte_value,
  output ted_pkg::scan_state_t      state_next,
  output ted_pkg::result_t          result
);

  logic [3:0] lead;

  always_comb begin
    lead       = ted_pkg::leading_ones(byte_value);
    state_next = state;

    if (state.bytes_seen != ted_pkg::HEAD_FULL) begin
      case (state.bytes_seen)
        2'd0:    state_next.head0 = byte_value;
        2'd1:    state_next.head1 = byte_value;
        default: state_next.head2 = byte_value;
      endcase
      state_next.bytes_seen = state.bytes_seen + 2'd1;
    end

    if (!state.scan_stopped && !state.scan_invalid) begin
      if (byte_value == 8'd0) begin
        state_next.scan_stopped = 1'b1;
      end else if (state.cont_due == 3'd0) begin
        if (byte_value[7]) begin
          state_next.all_ascii = 1'b0;
          if (lead == 4'd1 || lead > ted_pkg::MAX_LEAD) begin
            state_next.scan_invalid = 1'b1;
          end else begin
            state_next.cont_due = lead[2:0] - 3'd1;
          end
        end
      end else begin
        if ((byte_value & ted_pkg::CONT_MASK) != ted_pkg::CONT_MATCH) begin
          state_next.scan_invalid = 1'b1;
        end else begin
          state_next.cont_due = state.cont_due - 3'd1;
        end
      end
    end
  end

  always_comb begin
    if (state_next.bytes_seen == ted_pkg::HEAD_FULL && state_next.head0 == ted_pkg::BOM_EF &&
        state_next.head1 == ted_pkg::BOM_BB && state_next.head2 == ted_pkg::BOM_BF) begin
      result = '{encoding: ted_pkg::ENC_UTF8_MARK, mark_length: 2'd3};
    end else if (state_next.bytes_seen >= 2'd2 && state_next.head0 == ted_pkg::BOM_FF &&
                 state_next.head1 == ted_pkg::BOM_FE) begin
      result = '{encoding: ted_pkg::ENC_UTF16_LE, mark_length: 2'd2};
    end else if (state_next.bytes_seen >= 2'd2 && state_next.head0 == ted_pkg::BOM_FE &&
                 state_next.head1 == ted_pkg::BOM_FF) begin
      result = '{encoding: ted_pkg::ENC_UTF16_BE, mark_length: 2'd2};
    end else if (!state_next.scan_invalid && !state_next.all_ascii) begin
      result = '{encoding: ted_pkg::ENC_UTF8_NOMARK, mark_length: 2'd0};
    end else begin
      result = '{encoding: ted_pkg::ENC_ANSI, mark_length: 2'd0};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/text_encoding_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_encoding_detector
// Classifies a byte stream by byte-order mark and UTF-8 validity.
// ----------------------------------------------------------------------------
// Bytes of one file enter on the slave stream, tlast on the final byte. Bytes
// are taken back to back while the input does not stall; the scan state updates
// in the same cycle through a single leading-ones count and a few compares. The
// final byte loads one result (encoding class and mark length) into the output
// register, and the state returns to its reset value so the next file can
// follow at once. A second output slot absorbs a result while the master side
// stalls; input stalls only when both slots are full.
module text_encoding_detector (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] byte_value
  input  wire logic       s_tlast,   // is_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [2:0] encoding, [4:3] mark_length, [7:5] zero
);

  ted_pkg::scan_state_t state;
  ted_pkg::scan_state_t state_next;
  ted_pkg::result_t     step_result;
  ted_pkg::result_t     out_data;
  ted_pkg::result_t     skid_data;
  logic                 out_valid;
  logic                 skid_valid;
  logic                 accept;
  logic                 push;
  logic                 pop;

  ted_step u_step (
    .state      (state),
    .byte_value (s_tdata),
    .state_next (state_next),
    .result     (step_result)
  );

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;
  assign pop      = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ted_pkg::STATE_RESET;
    end else if (accept) begin
      state <= s_tlast ? ted_pkg::STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data  <= step_result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= step_result;
      skid_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_data.mark_length, out_data.encoding};

endmodule
`default_nettype wire

@@ dv/tb_text_encoding_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_encoding_detector
// Streams whole files byte by byte into the detector. A software copy of the
// mark and UTF-8 scan logic predicts each file's encoding class and mark
// length, and every returned result is compared with the oldest prediction.
// Both stream sides idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_text_encoding_detector;

  localparam int BYTE_TARGET = 1650;
  localparam int REPORT_CAP  = 10;

  class verdict_tracker;
    logic [1:0]       bytes_seen;
    logic [7:0]       head [3];
    logic [2:0]       cont_due;
    bit               all_ascii;
    bit               scan_bad;
    bit               scan_halted;
    ted_pkg::result_t pending [$];
    int               errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      bytes_seen  = '0;
      head[0]     = '0;
      head[1]     = '0;
      head[2]     = '0;
      cont_due    = '0;
      all_ascii   = 1'b1;
      scan_bad    = 1'b0;
      scan_halted = 1'b0;
    endfunction

    function int count_lead_ones(logic [7:0] b);
      int n;
      n = 0;
      while (n < 8 && b[7 - n]) n++;
      return n;
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void note_byte(logic [7:0] b, bit is_end);
      int               n;
      ted_pkg::result_t verdict;
      if (bytes_seen != ted_pkg::HEAD_FULL) begin
        head[bytes_seen] = b;
        bytes_seen++;
      end
      if (!scan_halted && !scan_bad) begin
        if (b == 8'h00) begin
          scan_halted = 1'b1;
        end else if (cont_due == 0) begin
          if (b[7]) begin
            n = count_lead_ones(b);
            all_ascii = 1'b0;
            if (n == 1 || n > ted_pkg::MAX_LEAD) scan_bad = 1'b1;
            else cont_due = 3'(n - 1);
          end
        end else if ((b & ted_pkg::CONT_MASK) != ted_pkg::CONT_MATCH) begin
          scan_bad = 1'b1;
        end else begin
          cont_due--;
        end
      end
      if (!is_end) return;
      if (bytes_seen == ted_pkg::HEAD_FULL && head[0] == ted_pkg::BOM_EF &&
          head[1] == ted_pkg::BOM_BB && head[2] == ted_pkg::BOM_BF) begin
        verdict = '{encoding: ted_pkg::ENC_UTF8_MARK, mark_length: 2'd3};
      end else if (bytes_seen >= 2 && head[0] == ted_pkg::BOM_FF &&
                   head[1] == ted_pkg::BOM_FE) begin
        verdict = '{encoding: ted_pkg::ENC_UTF16_LE, mark_length: 2'd2};
      end else if (bytes_seen >= 2 && head[0] == ted_pkg::BOM_FE &&
                   head[1] == ted_pkg::BOM_FF) begin
        verdict = '{encoding: ted_pkg::ENC_UTF16_BE, mark_length: 2'd2};
      end else if (!scan_bad && !all_ascii) begin
        verdict = '{encoding: ted_pkg::ENC_UTF8_NOMARK, mark_length: 2'd0};
      end else begin
        verdict = '{encoding: ted_pkg::ENC_ANSI, mark_length: 2'd0};
      end
      pending.insert(pending.size(), verdict);
      clear();
    endfunction

    function void check_verdict(logic [7:0] word);
      ted_pkg::result_t want;
      if (pending.size() == 0) begin
        flag("unexpected result", -1, word);
        return;
      end
      want = pending.pop_front();
      if (word[2:0] !== want.encoding) flag("encoding", want.encoding, word[2:0]);
      if (word[4:3] !== want.mark_length)
        flag("mark_length", want.mark_length, word[4:3]);
      if (word[7:5] !== 3'd0) flag("padding", 0, word[7:5]);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  verdict_tracker tracker;
  logic [7:0]     file_bytes [$];
  bit             steady;
  int             bytes_sent;

  text_encoding_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_text_encoding_detector: done, errors");
    $finish;
  end

  function automatic int pick_gap(int long_max);
    int roll;
    roll = $urandom_range(99);
    if (steady || roll < 65) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(long_max, 8);
  endfunction

  task automatic send_byte(logic [7:0] b, bit is_end);
    int gap;
    gap = pick_gap(30);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = is_end;
    do @(posedge clk); while (!s_tready);
    tracker.note_byte(b, is_end);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  task automatic load_file(logic [7:0] seq [$]);
    file_bytes = seq;
    send_file();
  endtask

  function automatic void append_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function automatic void add_char();
    int         n;
    logic [7:0] lead;
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(6, 2);
      lead = (8'hFF << (8 - n)) | (8'($urandom) & (8'hFF >> (n + 1)));
      append_byte(lead);
      repeat (n - 1) append_byte(ted_pkg::CONT_MATCH | 8'($urandom_range(63)));
    end else begin
      append_byte(8'($urandom_range(127, 1)));
    end
  endfunction

  function automatic void add_text(bit ascii_only);
    int chars;
    chars = ($urandom_range(99) < 85) ? $urandom_range(10, 1) : $urandom_range(40, 15);
    repeat (chars) begin
      if (ascii_only) append_byte(8'($urandom_range(127, 1)));
      else add_char();
    end
  endfunction

  function automatic void add_mark();
    case ($urandom_range(7))
      0, 1: file_bytes = {ted_pkg::BOM_EF, ted_pkg::BOM_BB, ted_pkg::BOM_BF};
      2:    file_bytes = {ted_pkg::BOM_FF, ted_pkg::BOM_FE};
      3:    file_bytes = {ted_pkg::BOM_FE, ted_pkg::BOM_FF};
      4:    file_bytes = {ted_pkg::BOM_EF, ted_pkg::BOM_BB};
      5:    file_bytes = {ted_pkg::BOM_EF, ted_pkg::BOM_BB, 8'($urandom)};
      6:    file_bytes = {ted_pkg::BOM_FF};
      default: file_bytes = {ted_pkg::BOM_FE, 8'($urandom)};
    endcase
  endfunction

  function automatic void build_random_file();
    int kind;
    int spot;
    kind = $urandom_range(99);
    if (kind < 25) begin
      add_text(1'b0);
    end else if (kind < 40) begin
      add_mark();
      if ($urandom_range(3) != 0) add_text(1'($urandom_range(1)));
    end else if (kind < 52) begin
      add_text(1'b1);
    end else if (kind < 65) begin
      add_text(1'b0);
      spot = $urandom_range(file_bytes.size());
      file_bytes.insert(spot, 8'h00);
      repeat ($urandom_range(4)) append_byte(8'($urandom));
    end else if (kind < 82) begin
      add_text(1'b0);
      spot = $urandom_range(file_bytes.size() - 1);
      case ($urandom_range(2))
        0: file_bytes[spot] = ted_pkg::CONT_MATCH | 8'($urandom_range(63));
        1: file_bytes[spot] = 8'($urandom_range(255, 254));
        default: file_bytes[spot] = 8'($urandom_range(127, 1));
      endcase
    end else if (kind < 90) begin
      add_text(1'b0);
      if (file_bytes.size() > 1) void'(file_bytes.pop_back());
    end else begin
      repeat ($urandom_range(20, 1)) append_byte(8'($urandom));
    end
  endfunction

  initial begin
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        m_tready = 1'b0;
      end else if (!steady && $urandom_range(99) < 30) begin
        stall = pick_gap(40);
        m_tready = (stall == 0);
      end else begin
        m_tready = 1'b1;
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_verdict(m_tdata);
    end
  end

  initial begin
    int file_no;
    tracker    = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_file({ted_pkg::BOM_EF, ted_pkg::BOM_BB, ted_pkg::BOM_BF, 8'h41});
    load_file({ted_pkg::BOM_FF, ted_pkg::BOM_FE});
    load_file({ted_pkg::BOM_FE, ted_pkg::BOM_FF});
    load_file({ted_pkg::BOM_EF, ted_pkg::BOM_BB});
    load_file({8'hFF});
    load_file({8'h41, 8'hFE});
    load_file({8'hC3, 8'hA9, 8'h00, 8'h80});
    load_file({8'h80, 8'hC3, 8'hA9});
    load_file({8'hC3, 8'h41});
    load_file({8'hFC, 8'h80});
    load_file({8'h00});

    file_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      steady = (file_no % 30) >= 20;
      build_random_file();
      send_file();
      file_no++;
    end
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_text_encoding_detector: done, clean");
    end else begin
      $display("tb_text_encoding_detector: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ted_pkg.sv
hw/rtl/ted_step.sv
hw/rtl/text_encoding_detector.sv
dv/tb_text_encoding_detector.sv
